### design/mlsh_pkg.sv
// Shared types and codes for the multi-axis limit-switch homing sequencer.
package mlsh_pkg;

  localparam int POS_BITS  = 16;
  localparam int ADC_BITS  = 12;
  localparam int AXIS_BITS = 3;

  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_POLL  = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_CHECK    = 3'd1;
  localparam logic [2:0] PH_TO_MIN   = 3'd2;
  localparam logic [2:0] PH_FREE_MIN = 3'd3;
  localparam logic [2:0] PH_TO_MAX   = 3'd4;
  localparam logic [2:0] PH_FREE_MAX = 3'd5;
  localparam logic [2:0] PH_MIDDLE   = 3'd6;
  localparam logic [2:0] PH_CAPTURE  = 3'd7;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;
  localparam logic [1:0] ST_FAIL = 2'd3;

  localparam logic [2:0] ERR_NONE          = 3'd0;
  localparam logic [2:0] ERR_BOTH_LIMITS   = 3'd1;
  localparam logic [2:0] ERR_MIN_UNREACHED = 3'd2;
  localparam logic [2:0] ERR_MIN_STUCK     = 3'd3;
  localparam logic [2:0] ERR_MAX_UNREACHED = 3'd4;
  localparam logic [2:0] ERR_MAX_STUCK     = 3'd5;
  localparam logic [2:0] ERR_MID_UNREACHED = 3'd6;

  localparam logic [1:0] STEP_NONE = 2'd0;
  localparam logic [1:0] STEP_DOWN = 2'd1;
  localparam logic [1:0] STEP_UP   = 2'd2;

  localparam logic REG_ACTIVE_AXES = 1'b0;
  localparam logic REG_TIMEOUT     = 1'b1;

  localparam logic [3:0]  ACTIVE_AXES_RESET = 4'd1;
  localparam logic [15:0] TIMEOUT_RESET     = 16'd30000;

  localparam logic signed [POS_BITS-1:0] POS_MAX = {1'b0, {(POS_BITS-1){1'b1}}};
  localparam logic signed [POS_BITS-1:0] POS_MIN = {1'b1, {(POS_BITS-1){1'b0}}};

  typedef struct packed {
    logic [1:0]          func;
    logic                min_limit;
    logic                max_limit;
    logic [ADC_BITS-1:0] adc_sample;
  } item_t;

  typedef struct packed {
    logic [AXIS_BITS-1:0]        axis;
    logic [1:0]                  step_cmd;
    logic [2:0]                  phase;
    logic [1:0]                  status;
    logic [2:0]                  error_code;
    logic [AXIS_BITS-1:0]        next_axis;
    logic signed [POS_BITS-1:0]  position;
    logic signed [POS_BITS-1:0]  endpoint_max_out;
    logic signed [POS_BITS-1:0]  endpoint_mid_out;
    logic [ADC_BITS-1:0]         adc_min_out;
    logic [ADC_BITS-1:0]         adc_max_out;
    logic [ADC_BITS-1:0]         adc_mid_out;
  } result_t;

  typedef struct packed {
    logic signed [POS_BITS-1:0] position;
    logic signed [POS_BITS-1:0] max_ep;
    logic signed [POS_BITS-1:0] mid_ep;
    logic [ADC_BITS-1:0]        min_adc;
    logic [ADC_BITS-1:0]        max_adc;
    logic [ADC_BITS-1:0]        mid_adc;
  } axis_entry_t;

endpackage

### design/mlsh_out_fifo.sv
// Two-entry result queue between the execute stage and the result channel.
module mlsh_out_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mlsh_pkg::result_t push_data,
  output logic [1:0]       count,
  output logic             result_valid,
  input  logic             result_ready,
  output mlsh_pkg::result_t result
);
  import mlsh_pkg::*;

  result_t entries [2];
  logic    wr_ptr;
  logic    rd_ptr;
  logic    pop;

  assign pop          = result_valid & result_ready;
  assign result_valid = (count != 2'd0);
  assign result       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

### design/multi_axis_limit_switch_homing.sv
// Multi-axis limit-switch homing sequencer: per-axis state in a registered-read memory.
// A result passes through the memory read, the execute stage and the output queue.
// Throughput: one item per cycle while the output queue has room; the memory read is issued
// on accept, and a write-back from the item just ahead is forwarded into the execute stage.
// Reset: control state idle, per-axis entries read as zero until written, config to defaults.
module multi_axis_limit_switch_homing #(
  parameter int MAX_AXES = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  mlsh_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output mlsh_pkg::result_t result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import mlsh_pkg::*;

  localparam int PTR_W = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;
  localparam logic [4:0] AXES_C = 5'(MAX_AXES);

  // configuration
  logic [3:0]  active_axes;
  logic [15:0] phase_timeout_ms;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_axes      <= ACTIVE_AXES_RESET;
      phase_timeout_ms <= TIMEOUT_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_ACTIVE_AXES: active_axes      <= pwdata[3:0];
        REG_TIMEOUT:     phase_timeout_ms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ACTIVE_AXES: prdata = {28'd0, active_axes};
      REG_TIMEOUT:     prdata = {16'd0, phase_timeout_ms};
      default:         prdata = 32'd0;
    endcase
  end

  // control state
  logic [2:0]       phase_reg, phase_next;
  logic [1:0]       status_reg, status_next;
  logic [2:0]       error_reg, error_next;
  logic [PTR_W-1:0] axis_pointer, ptr_next;
  logic             pass_clean, clean_next;
  logic [15:0]      elapsed_ms, elapsed_next;

  // execute stage
  logic             s1_valid;
  item_t            s1_item;
  logic [PTR_W-1:0] s1_axis;

  // per-axis memory
  axis_entry_t      axis_mem [MAX_AXES];
  logic [MAX_AXES-1:0] entry_written;
  axis_entry_t      mem_q;
  logic             fwd_valid;
  logic [PTR_W-1:0] fwd_addr;
  axis_entry_t      fwd_data;

  logic             item_fire;
  logic [PTR_W-1:0] rd_addr;
  logic             mem_we;
  axis_entry_t      entry_cur, entry_new;
  logic [1:0]       step;
  logic [2:0]       fail_code;
  logic             clean_after;
  logic             last;
  logic [4:0]       axis_cnt;
  logic [4:0]       a_inc;
  logic [PTR_W-1:0] ptr_inc;
  logic signed [POS_BITS-1:0] half_sum;
  logic signed [POS_BITS-1:0] mid_val;
  result_t          res;
  logic [1:0]       fifo_count;
  logic             pop;
  logic [2:0]       occ_next;

  assign item_fire = item_valid & item_ready;
  assign rd_addr   = (item.func == FUNC_START) ? '0 : ptr_next;
  assign pop       = result_valid & result_ready;
  assign occ_next  = 3'(fifo_count) + 3'(s1_valid) - 3'(pop);
  assign item_ready = (occ_next < 3'd2);

  always_comb begin
    if (active_axes == 4'd0) begin
      axis_cnt = 5'd1;
    end else if ({1'b0, active_axes} > AXES_C) begin
      axis_cnt = AXES_C;
    end else begin
      axis_cnt = {1'b0, active_axes};
    end
    a_inc   = 5'(s1_axis) + 5'd1;
    last    = (a_inc >= axis_cnt);
    ptr_inc = (a_inc >= AXES_C) ? '0 : a_inc[PTR_W-1:0];
  end

  always_comb begin
    if (fwd_valid && fwd_addr == s1_axis) begin
      entry_cur = fwd_data;
    end else if (entry_written[s1_axis]) begin
      entry_cur = mem_q;
    end else begin
      entry_cur = '0;
    end
  end

  always_comb begin
    phase_next   = phase_reg;
    status_next  = status_reg;
    error_next   = error_reg;
    ptr_next     = axis_pointer;
    clean_next   = pass_clean;
    elapsed_next = elapsed_ms;
    entry_new    = entry_cur;
    step         = STEP_NONE;
    fail_code    = ERR_NONE;
    clean_after  = pass_clean;
    mem_we       = 1'b0;
    half_sum     = entry_cur.max_ep
                   + $signed({{(POS_BITS-1){1'b0}}, entry_cur.max_ep[POS_BITS-1]});
    mid_val      = {half_sum[POS_BITS-1], half_sum[POS_BITS-1:1]};
    if (s1_valid) begin
      case (s1_item.func)
        FUNC_START: begin
          status_next  = ST_BUSY;
          error_next   = ERR_NONE;
          phase_next   = PH_CHECK;
          ptr_next     = '0;
          clean_next   = 1'b1;
          elapsed_next = 16'd0;
        end
        FUNC_TICK: begin
          if (status_reg == ST_BUSY && phase_reg inside {[PH_TO_MIN:PH_MIDDLE]} &&
              elapsed_ms != 16'hFFFF) begin
            elapsed_next = elapsed_ms + 16'd1;
          end
        end
        FUNC_POLL: begin
          if (status_reg == ST_BUSY) begin
            mem_we = 1'b1;
            case (phase_reg)
              PH_CHECK: begin
                if (s1_item.min_limit && s1_item.max_limit) begin
                  status_next = ST_FAIL;
                  error_next  = ERR_BOTH_LIMITS;
                  ptr_next    = '0;
                end
              end
              PH_TO_MIN: begin
                fail_code = ERR_MIN_UNREACHED;
                if (!s1_item.min_limit) begin
                  step = STEP_DOWN;
                end
              end
              PH_FREE_MIN: begin
                fail_code = ERR_MIN_STUCK;
                if (s1_item.min_limit) begin
                  step = STEP_UP;
                end else begin
                  entry_new.position = '0;
                  entry_new.min_adc  = s1_item.adc_sample;
                end
              end
              PH_TO_MAX: begin
                fail_code = ERR_MAX_UNREACHED;
                if (!s1_item.max_limit) begin
                  step = STEP_UP;
                end
              end
              PH_FREE_MAX: begin
                fail_code = ERR_MAX_STUCK;
                if (s1_item.max_limit) begin
                  step = STEP_DOWN;
                end else begin
                  entry_new.max_ep  = entry_cur.position;
                  entry_new.max_adc = s1_item.adc_sample;
                end
              end
              PH_MIDDLE: begin
                fail_code        = ERR_MID_UNREACHED;
                entry_new.mid_ep = mid_val;
                if ($signed(entry_cur.position) > mid_val) begin
                  step = STEP_DOWN;
                end
              end
              PH_CAPTURE: begin
                entry_new.mid_adc = s1_item.adc_sample;
              end
              default: ;
            endcase
            if (step == STEP_DOWN && entry_cur.position != POS_MIN) begin
              entry_new.position = entry_cur.position - POS_BITS'(1);
            end else if (step == STEP_UP && entry_cur.position != POS_MAX) begin
              entry_new.position = entry_cur.position + POS_BITS'(1);
            end
            clean_after = pass_clean & (step == STEP_NONE);
            clean_next  = clean_after;
            if (status_next == ST_BUSY) begin
              if (last) begin
                ptr_next = '0;
                if (clean_after) begin
                  if (phase_reg == PH_CAPTURE) begin
                    phase_next  = PH_IDLE;
                    status_next = ST_DONE;
                  end else begin
                    phase_next   = phase_reg + 3'd1;
                    clean_next   = 1'b1;
                    elapsed_next = 16'd0;
                  end
                end else if (elapsed_ms >= phase_timeout_ms) begin
                  status_next = ST_FAIL;
                  error_next  = fail_code;
                end else begin
                  clean_next = 1'b1;
                end
              end else begin
                ptr_next = ptr_inc;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res.axis             = AXIS_BITS'(s1_axis);
    res.step_cmd         = step;
    res.phase            = phase_next;
    res.status           = status_next;
    res.error_code       = error_next;
    res.next_axis        = AXIS_BITS'(ptr_next);
    res.position         = entry_new.position;
    res.endpoint_max_out = entry_new.max_ep;
    res.endpoint_mid_out = entry_new.mid_ep;
    res.adc_min_out      = entry_new.min_adc;
    res.adc_max_out      = entry_new.max_adc;
    res.adc_mid_out      = entry_new.mid_adc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg     <= PH_IDLE;
      status_reg    <= ST_IDLE;
      error_reg     <= ERR_NONE;
      axis_pointer  <= '0;
      pass_clean    <= 1'b1;
      elapsed_ms    <= 16'd0;
      s1_valid      <= 1'b0;
      fwd_valid     <= 1'b0;
      entry_written <= '0;
    end else begin
      phase_reg    <= phase_next;
      status_reg   <= status_next;
      error_reg    <= error_next;
      axis_pointer <= ptr_next;
      pass_clean   <= clean_next;
      elapsed_ms   <= elapsed_next;
      s1_valid     <= item_fire;
      fwd_valid    <= s1_valid & mem_we;
      if (s1_valid && mem_we) begin
        entry_written[s1_axis] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire) begin
      s1_item <= item;
      s1_axis <= rd_addr;
    end
    fwd_addr <= s1_axis;
    fwd_data <= entry_new;
  end

  always_ff @(posedge clk) begin
    if (s1_valid && mem_we) begin
      axis_mem[s1_axis] <= entry_new;
    end
    if (item_fire) begin
      mem_q <= axis_mem[rd_addr];
    end
  end

  mlsh_out_fifo u_out_fifo (
    .clk          (clk),
    .rst          (rst),
    .push         (s1_valid),
    .push_data    (res),
    .count        (fifo_count),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

### sim/tb_multi_axis_limit_switch_homing.sv
// Self-checking testbench for the multi-axis limit-switch homing sequencer.
module tb_multi_axis_limit_switch_homing;
  timeunit 1ns;
  timeprecision 1ps;
  import mlsh_pkg::*;

  localparam int NUM_AXES = 8;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  class homing_predictor;
    int unsigned axes_cfg;
    int unsigned timeout_cfg;
    bit [2:0] phase_r;
    bit [1:0] status_r;
    bit [2:0] err_r;
    bit [2:0] ptr_r;
    bit clean_r;
    bit [15:0] elapsed_r;
    bit signed [POS_BITS-1:0] pos [NUM_AXES];
    bit signed [POS_BITS-1:0] max_ep [NUM_AXES];
    bit signed [POS_BITS-1:0] mid_ep [NUM_AXES];
    bit [ADC_BITS-1:0] min_adc [NUM_AXES];
    bit [ADC_BITS-1:0] max_adc [NUM_AXES];
    bit [ADC_BITS-1:0] mid_adc [NUM_AXES];
    result_t expected_results[$];
    int errors;

    function new();
      axes_cfg = ACTIVE_AXES_RESET;
      timeout_cfg = TIMEOUT_RESET;
      phase_r = PH_IDLE;
      status_r = ST_IDLE;
      err_r = ERR_NONE;
      ptr_r = '0;
      clean_r = 1'b1;
      elapsed_r = '0;
      errors = 0;
      foreach (pos[i]) begin
        pos[i] = '0;
        max_ep[i] = '0;
        mid_ep[i] = '0;
        min_adc[i] = '0;
        max_adc[i] = '0;
        mid_adc[i] = '0;
      end
    endfunction

    function void begin_phase(bit [2:0] ph);
      phase_r = ph;
      ptr_r = '0;
      clean_r = 1'b1;
      elapsed_r = '0;
    endfunction

    function void end_pass(bit [2:0] code);
      if (clean_r) begin
        if (phase_r == PH_CAPTURE) begin
          phase_r = PH_IDLE;
          status_r = ST_DONE;
          ptr_r = '0;
        end else begin
          begin_phase(phase_r + 3'd1);
        end
      end else if (elapsed_r >= timeout_cfg) begin
        status_r = ST_FAIL;
        err_r = code;
        ptr_r = '0;
      end else begin
        ptr_r = '0;
        clean_r = 1'b1;
      end
    endfunction

    function result_t note_item(item_t it);
      result_t exp;
      bit [2:0] a;
      bit [1:0] step;
      bit [2:0] code;
      bit lastp;
      int n;
      a = ptr_r;
      step = STEP_NONE;
      code = ERR_NONE;
      n = (axes_cfg == 0) ? 1 : ((axes_cfg > NUM_AXES) ? NUM_AXES : axes_cfg);
      if (it.func == FUNC_START) begin
        status_r = ST_BUSY;
        err_r = ERR_NONE;
        begin_phase(PH_CHECK);
        a = '0;
      end else if (it.func == FUNC_TICK) begin
        if (status_r == ST_BUSY && phase_r >= PH_TO_MIN && phase_r <= PH_MIDDLE &&
            elapsed_r != 16'hFFFF)
          elapsed_r = elapsed_r + 16'd1;
      end else if (it.func == FUNC_POLL && status_r == ST_BUSY) begin
        lastp = (int'(a) + 1) >= n;
        case (phase_r)
          PH_CHECK: begin
            if (it.min_limit && it.max_limit) begin
              status_r = ST_FAIL;
              err_r = ERR_BOTH_LIMITS;
              ptr_r = '0;
            end
          end
          PH_TO_MIN: begin
            code = ERR_MIN_UNREACHED;
            if (!it.min_limit) begin
              step = STEP_DOWN;
              clean_r = 1'b0;
            end
          end
          PH_FREE_MIN: begin
            code = ERR_MIN_STUCK;
            if (it.min_limit) begin
              step = STEP_UP;
              clean_r = 1'b0;
            end else begin
              pos[a] = '0;
              min_adc[a] = it.adc_sample;
            end
          end
          PH_TO_MAX: begin
            code = ERR_MAX_UNREACHED;
            if (!it.max_limit) begin
              step = STEP_UP;
              clean_r = 1'b0;
            end
          end
          PH_FREE_MAX: begin
            code = ERR_MAX_STUCK;
            if (it.max_limit) begin
              step = STEP_DOWN;
              clean_r = 1'b0;
            end else begin
              max_ep[a] = pos[a];
              max_adc[a] = it.adc_sample;
            end
          end
          PH_MIDDLE: begin
            code = ERR_MID_UNREACHED;
            mid_ep[a] = POS_BITS'(int'(max_ep[a]) / 2);
            if (pos[a] > mid_ep[a]) begin
              step = STEP_DOWN;
              clean_r = 1'b0;
            end
          end
          PH_CAPTURE: mid_adc[a] = it.adc_sample;
          default: ;
        endcase
        if (step == STEP_DOWN && pos[a] != POS_MIN)
          pos[a] = pos[a] - POS_BITS'(1);
        else if (step == STEP_UP && pos[a] != POS_MAX)
          pos[a] = pos[a] + POS_BITS'(1);
        if (status_r == ST_BUSY) begin
          if (lastp)
            end_pass(code);
          else
            ptr_r = a + 3'd1;
        end
      end
      exp.axis = a;
      exp.step_cmd = step;
      exp.phase = phase_r;
      exp.status = status_r;
      exp.error_code = err_r;
      exp.next_axis = ptr_r;
      exp.position = pos[a];
      exp.endpoint_max_out = max_ep[a];
      exp.endpoint_mid_out = mid_ep[a];
      exp.adc_min_out = min_adc[a];
      exp.adc_max_out = max_adc[a];
      exp.adc_mid_out = mid_adc[a];
      expected_results.push_back(exp);
      return exp;
    endfunction

    function void check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (expected_results.size() == 0) begin
        $error("result transaction with nothing expected: axis %0d", got.axis);
        errors++;
        return;
      end
      exp = expected_results.pop_front();
      check_field("axis", exp.axis, got.axis);
      check_field("step_cmd", exp.step_cmd, got.step_cmd);
      check_field("phase", exp.phase, got.phase);
      check_field("status", exp.status, got.status);
      check_field("error_code", exp.error_code, got.error_code);
      check_field("next_axis", exp.next_axis, got.next_axis);
      check_field("position", exp.position, got.position);
      check_field("endpoint_max_out", exp.endpoint_max_out, got.endpoint_max_out);
      check_field("endpoint_mid_out", exp.endpoint_mid_out, got.endpoint_mid_out);
      check_field("adc_min_out", exp.adc_min_out, got.adc_min_out);
      check_field("adc_max_out", exp.adc_max_out, got.adc_max_out);
      check_field("adc_mid_out", exp.adc_mid_out, got.adc_mid_out);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  item_t       item = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  result_t     result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  homing_predictor homing;
  bit idling = 1'b1;
  bit hold_request = 1'b0;
  int phys [NUM_AXES];
  int span [NUM_AXES];
  bit stuck_min [NUM_AXES];
  bit stuck_max [NUM_AXES];
  int axes_plan [8] = '{1, 8, 3, 15, 0, 8, 2, 5};
  int timeout_plan [8] = '{30000, 65535, 2, 5, 0, 1, 30000, 3};

  multi_axis_limit_switch_homing dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready)
      homing.check_result(result);
  end

  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        stall--;
        result_ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        stall = 79;
        result_ready <= 1'b0;
      end else if (idling && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(0, 6);
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // Sends one transaction; the axis plant follows the predicted step.
  task automatic send(item_t it);
    result_t exp;
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    exp = homing.note_item(it);
    if (exp.step_cmd == STEP_DOWN)
      phys[exp.axis]--;
    else if (exp.step_cmd == STEP_UP)
      phys[exp.axis]++;
    if (idling && $urandom_range(0, 5) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic put(logic [1:0] f, logic mn, logic mx, logic [ADC_BITS-1:0] adc);
    item_t it;
    it.func = f;
    it.min_limit = mn;
    it.max_limit = mx;
    it.adc_sample = adc;
    send(it);
  endtask

  task automatic settle();
    item_valid <= 1'b0;
    while (homing.expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_ACTIVE_AXES)
      homing.axes_cfg = 32'(data[3:0]);
    else
      homing.timeout_cfg = 32'(data[15:0]);
  endtask

  function automatic item_t next_random();
    item_t it;
    int r;
    bit [2:0] a;
    it.func = 2'($urandom_range(0, 3));
    it.min_limit = 1'($urandom_range(0, 1));
    it.max_limit = 1'($urandom_range(0, 1));
    it.adc_sample = ADC_BITS'($urandom);
    r = $urandom_range(0, 99);
    if (homing.status_r != ST_BUSY) begin
      if (r < 75) begin
        it.func = FUNC_START;
        foreach (phys[i]) begin
          span[i] = $urandom_range(1, 6);
          phys[i] = int'($urandom_range(0, span[i] + 2)) - 1;
          stuck_min[i] = ($urandom_range(0, 24) == 0);
          stuck_max[i] = ($urandom_range(0, 24) == 0);
        end
      end
    end else if (r < 12) begin
      it.func = FUNC_TICK;
    end else if (r == 16) begin
      it.func = FUNC_START;
    end else if (r >= 16) begin
      a = homing.ptr_r;
      it.func = FUNC_POLL;
      it.min_limit = (phys[a] <= 0) || stuck_min[a];
      it.max_limit = (phys[a] >= span[a]) || stuck_max[a];
      if (r >= 98)
        it.max_limit = ~it.max_limit;
      else if (r >= 96)
        it.min_limit = ~it.min_limit;
    end
    return it;
  endfunction

  initial begin
    item_t it;
    homing = new();
    foreach (phys[i]) begin
      span[i] = 1;
      phys[i] = 0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    write_reg(REG_ACTIVE_AXES, 32'd1);
    write_reg(REG_TIMEOUT, 32'd30000);

    put(FUNC_UNUSED, 1'b1, 1'b1, 12'hFFF);
    put(FUNC_TICK, 1'b0, 1'b0, 12'h000);
    put(FUNC_POLL, 1'b1, 1'b1, 12'h000);
    put(FUNC_START, 1'b0, 1'b0, 12'hABC);
    put(FUNC_POLL, 1'b1, 1'b1, 12'h123);     // both switches hit
    put(FUNC_POLL, 1'b0, 1'b0, 12'h456);     // ignored after a failure
    put(FUNC_START, 1'b0, 1'b0, 12'h000);
    put(FUNC_POLL, 1'b0, 1'b0, 12'h001);
    put(FUNC_TICK, 1'b1, 1'b0, 12'h000);
    put(FUNC_POLL, 1'b1, 1'b0, 12'h002);
    put(FUNC_POLL, 1'b1, 1'b0, 12'h003);
    put(FUNC_START, 1'b1, 1'b1, 12'hFFF);    // restart while busy
    put(FUNC_POLL, 1'b0, 1'b0, 12'h004);
    put(FUNC_POLL, 1'b1, 1'b0, 12'h005);
    put(FUNC_POLL, 1'b0, 1'b0, 12'hFFF);
    put(FUNC_POLL, 1'b0, 1'b1, 12'h006);
    repeat (3) put(FUNC_POLL, 1'b0, 1'b1, 12'h007);
    put(FUNC_POLL, 1'b0, 1'b0, 12'h800);     // negative odd max endpoint
    put(FUNC_POLL, 1'b0, 1'b0, 12'h009);
    put(FUNC_POLL, 1'b0, 1'b0, 12'h555);
    put(FUNC_POLL, 1'b1, 1'b1, 12'hAAA);
    settle();

    idling = 1'b1;
    for (int rnd = 0; rnd < 8; rnd++) begin
      write_reg(REG_ACTIVE_AXES, axes_plan[rnd]);
      write_reg(REG_TIMEOUT, timeout_plan[rnd]);
      if (rnd == 1)
        hold_request = 1'b1;
      if (rnd >= 6)
        idling = 1'b0;
      repeat (66) begin
        it = next_random();
        send(it);
      end
      settle();
    end

    if (homing.errors == 0 && homing.expected_results.size() == 0)
      $display("multi_axis_limit_switch_homing: match");
    else
      $display("multi_axis_limit_switch_homing: mismatch");
    $finish;
  end

  initial begin
    #5ms;
    $display("multi_axis_limit_switch_homing: mismatch");
    $finish;
  end

endmodule

### filelist.f
design/mlsh_pkg.sv
design/mlsh_out_fifo.sv
design/multi_axis_limit_switch_homing.sv
sim/tb_multi_axis_limit_switch_homing.sv
